// File: src/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared constants, codes and types of the piecewise linear bin mapper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plm_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SP_W        = IDX_W + 1;
  localparam int CNT_W       = 5;
  localparam int DIFF_W      = VALUE_WIDTH + 1;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  localparam int DIV_STEPS   = (PROD_W + 1) / 2;
  localparam int DIVD_W      = 2 * DIV_STEPS;
  localparam int DCNT_W      = $clog2(DIV_STEPS + 1);
  localparam int SUM_W       = DIVD_W + 2;

  localparam int CFG_IDX_W   = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERPOLATE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_BELOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_ABOVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BELOW_VALUE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE_VALUE = 3'd5;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] src;
    logic [VALUE_WIDTH-1:0] tgt;
  } pair_t;

  typedef struct packed {
    logic                   start;
    logic [DIVD_W-1:0]      dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: src/plm_table.sv
// ----------------------------------------------------------------------------
// plm_table
// Breakpoint pair memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plm_table
  import plm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire pair_t            wdata_i,
  input  wire logic [IDX_W-1:0] raddr_a_i,
  input  wire logic [IDX_W-1:0] raddr_b_i,
  output pair_t                 rdata_a_o,
  output pair_t                 rdata_b_o
);

  pair_t mem [TABLE_DEPTH];
  pair_t rdata_a_q;
  pair_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: src/plm_div.sv
// ----------------------------------------------------------------------------
// plm_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plm_div
  import plm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [DCNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0]      quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] dvs_q, dvs_d;
  logic [DIFF_W-1:0]      r_a, r_b;
  logic                   b_a, b_b;

  always_comb begin
    r_a = {rem_q, quo_q[DIVD_W-1]};
    b_a = (r_a >= {1'b0, dvs_q});
    if (b_a) begin
      r_a = r_a - {1'b0, dvs_q};
    end
    r_b = {r_a[VALUE_WIDTH-1:0], quo_q[DIVD_W-2]};
    b_b = (r_b >= {1'b0, dvs_q});
    if (b_b) begin
      r_b = r_b - {1'b0, dvs_q};
    end

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIV_STEPS);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = r_b[VALUE_WIDTH-1:0];
      quo_d = {quo_q[DIVD_W-3:0], b_a, b_b};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// File: src/piecewise_linear_bin_mapper.sv
// ----------------------------------------------------------------------------
// piecewise_linear_bin_mapper
// Maps Q16.16 samples through a table of ascending breakpoint pairs by binary
// search, returning the bin's lower target, a linear interpolation or an out-of-range value.
// ----------------------------------------------------------------------------
// load request: written to the table as it is taken, no result, busy stays low
// sample request: a below-range result is decided in S_EDGE; each search probe
//   (one table read pair) passes S_SRCH_RD and S_SRCH_CMP; interpolation adds
//   S_MUL, S_DIV_GO and S_DIV_WAIT, the last waiting on the two-bit-per-cycle divider
// a new request is taken in the cycle the result strobe shows
// reset clears control and config registers (count resets to 2); table entries stay undefined
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_bin_mapper
  import plm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind_i,
  input  wire logic        [IDX_W-1:0]       entry_index_i,
  input  wire logic signed [VALUE_WIDTH-1:0] source_point_i,
  input  wire logic signed [VALUE_WIDTH-1:0] target_point_i,
  input  wire logic signed [VALUE_WIDTH-1:0] sample_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic        [VALUE_WIDTH-1:0] cfg_wdata_i,
  output logic                               result_valid_o,
  output logic signed      [VALUE_WIDTH-1:0] mapped_value_o,
  output logic                               saturated_o
);

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] S_EDGE     = 3'd1;
  localparam logic [ST_W-1:0] S_SRCH_RD  = 3'd2;
  localparam logic [ST_W-1:0] S_SRCH_CMP = 3'd3;
  localparam logic [ST_W-1:0] S_MUL      = 3'd4;
  localparam logic [ST_W-1:0] S_DIV_GO   = 3'd5;
  localparam logic [ST_W-1:0] S_DIV_WAIT = 3'd6;

  localparam logic signed [SUM_W-1:0] SUM_MAX =
    {{(SUM_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = ~SUM_MAX;

  // config
  logic [CNT_W-1:0]       count_q;
  logic                   interp_q;
  logic                   clamp_lo_q;
  logic                   clamp_hi_q;
  logic [VALUE_WIDTH-1:0] below_q;
  logic [VALUE_WIDTH-1:0] above_q;

  // control and datapath
  logic [ST_W-1:0]        state_q, state_d;
  logic                   valid_q, valid_d;
  logic [VALUE_WIDTH-1:0] res_q, res_d;
  logic                   sat_q, sat_d;
  logic [VALUE_WIDTH-1:0] v_q, v_d;
  logic [IDX_W-1:0]       last_q, last_d;
  logic [SP_W-1:0]        lo_q, lo_d;
  logic [SP_W-1:0]        hi_q, hi_d;
  logic [IDX_W-1:0]       mid_q, mid_d;
  logic [VALUE_WIDTH-1:0] slast_q, slast_d;
  logic [VALUE_WIDTH-1:0] tlast_q, tlast_d;
  logic [VALUE_WIDTH-1:0] t0_q, t0_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] num_q, num_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [VALUE_WIDTH-1:0] ds_q, ds_d;
  logic [PROD_W-1:0]      prod_q, prod_d;

  logic                   accept;
  logic [IDX_W-1:0]       last_cfg;
  logic [SP_W-1:0]        span;
  logic [SP_W-1:0]        mid_w;
  logic [IDX_W-1:0]       raddr_a, raddr_b;
  pair_t                  rd_a, rd_b, wpair;
  logic [DIFF_W-1:0]      ds_w, dt_w, num_w, mag_w;
  logic signed [SUM_W-1:0] t0_ext, q_ext, sum_w;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    if (count_q < CNT_W'(2)) begin
      last_cfg = IDX_W'(1);
    end else if (count_q > CNT_W'(TABLE_DEPTH)) begin
      last_cfg = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      last_cfg = IDX_W'(count_q - CNT_W'(1));
    end
  end

  assign span  = hi_q - lo_q;
  assign mid_w = lo_q + (span >> 1);

  always_comb begin
    raddr_a = '0;
    raddr_b = last_cfg;
    if (state_q == S_SRCH_RD) begin
      raddr_a = mid_w[IDX_W-1:0] - IDX_W'(1);
      raddr_b = mid_w[IDX_W-1:0];
    end
  end

  assign wpair.src = source_point_i;
  assign wpair.tgt = target_point_i;

  plm_table u_table (
    .clk_i     (clk_i),
    .we_i      (accept && (kind_i == KIND_LOAD)),
    .waddr_i   (entry_index_i),
    .wdata_i   (wpair),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign div_req.start    = (state_q == S_DIV_GO);
  assign div_req.dividend = DIVD_W'(prod_q);
  assign div_req.divisor  = ds_q;

  plm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // bin differences
  assign ds_w  = {rd_b.src[VALUE_WIDTH-1], rd_b.src} - {rd_a.src[VALUE_WIDTH-1], rd_a.src};
  assign dt_w  = {rd_b.tgt[VALUE_WIDTH-1], rd_b.tgt} - {rd_a.tgt[VALUE_WIDTH-1], rd_a.tgt};
  assign num_w = {v_q[VALUE_WIDTH-1], v_q} - {rd_a.src[VALUE_WIDTH-1], rd_a.src};
  assign mag_w = dt_w[DIFF_W-1] ? (~dt_w + DIFF_W'(1)) : dt_w;

  // final add or subtract
  assign t0_ext = $signed({{(SUM_W-VALUE_WIDTH){t0_q[VALUE_WIDTH-1]}}, t0_q});
  assign q_ext  = $signed({2'b00, div_rsp.quotient});
  assign sum_w  = neg_q ? (t0_ext - q_ext) : (t0_ext + q_ext);

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    res_d   = res_q;
    sat_d   = sat_q;
    v_d     = v_q;
    last_d  = last_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    slast_d = slast_q;
    tlast_d = tlast_q;
    t0_d    = t0_q;
    neg_d   = neg_q;
    num_d   = num_q;
    mag_d   = mag_q;
    ds_d    = ds_q;
    prod_d  = prod_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == KIND_SAMPLE)) begin
          v_d     = sample_value_i;
          last_d  = last_cfg;
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        slast_d = rd_b.src;
        tlast_d = rd_b.tgt;
        if ($signed(v_q) < $signed(rd_a.src)) begin
          res_d   = clamp_lo_q ? rd_a.tgt : below_q;
          sat_d   = 1'b0;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          lo_d    = SP_W'(1);
          hi_d    = {1'b0, last_q};
          state_d = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (lo_q > hi_q) begin
          // no bin found
          if ($signed(v_q) > $signed(slast_q)) begin
            res_d = clamp_hi_q ? tlast_q : above_q;
          end else begin
            res_d = tlast_q;
          end
          sat_d   = 1'b0;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          mid_d   = mid_w[IDX_W-1:0];
          state_d = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (($signed(v_q) >= $signed(rd_a.src)) && ($signed(v_q) < $signed(rd_b.src))) begin
          t0_d  = rd_a.tgt;
          neg_d = dt_w[DIFF_W-1];
          num_d = num_w[VALUE_WIDTH-1:0];
          mag_d = mag_w[VALUE_WIDTH-1:0];
          ds_d  = ds_w[VALUE_WIDTH-1:0];
          if (interp_q && !ds_w[DIFF_W-1] && (ds_w != '0) && !num_w[DIFF_W-1]) begin
            state_d = S_MUL;
          end else begin
            res_d   = rd_a.tgt;
            sat_d   = 1'b0;
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
        end else if ($signed(v_q) >= $signed(rd_b.src)) begin
          lo_d    = {1'b0, mid_q} + SP_W'(1);
          state_d = S_SRCH_RD;
        end else begin
          hi_d    = {1'b0, mid_q} - SP_W'(1);
          state_d = S_SRCH_RD;
        end
      end
      S_MUL: begin
        prod_d  = num_q * mag_q;
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (sum_w > SUM_MAX) begin
            res_d = SUM_MAX[VALUE_WIDTH-1:0];
            sat_d = 1'b1;
          end else if (sum_w < SUM_MIN) begin
            res_d = SUM_MIN[VALUE_WIDTH-1:0];
            sat_d = 1'b1;
          end else begin
            res_d = sum_w[VALUE_WIDTH-1:0];
            sat_d = 1'b0;
          end
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= 1'b0;
      count_q    <= CNT_W'(2);
      interp_q   <= 1'b0;
      clamp_lo_q <= 1'b0;
      clamp_hi_q <= 1'b0;
      below_q    <= '0;
      above_q    <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_COUNT:       count_q    <= cfg_wdata_i[CNT_W-1:0];
          CFG_INTERPOLATE: interp_q   <= cfg_wdata_i[0];
          CFG_CLAMP_BELOW: clamp_lo_q <= cfg_wdata_i[0];
          CFG_CLAMP_ABOVE: clamp_hi_q <= cfg_wdata_i[0];
          CFG_BELOW_VALUE: below_q    <= cfg_wdata_i;
          CFG_ABOVE_VALUE: above_q    <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    sat_q   <= sat_d;
    v_q     <= v_d;
    last_q  <= last_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    slast_q <= slast_d;
    tlast_q <= tlast_d;
    t0_q    <= t0_d;
    neg_q   <= neg_d;
    num_q   <= num_d;
    mag_q   <= mag_d;
    ds_q    <= ds_d;
    prod_q  <= prod_d;
  end

  assign result_valid_o = valid_q;
  assign mapped_value_o = res_q;
  assign saturated_o    = sat_q;

endmodule

`default_nettype wire

// File: src/plm_checker.sv
// ----------------------------------------------------------------------------
// plm_checker
// Port-level checks of request and result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plm_checker
  import plm_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic kind_i,
  input wire logic result_valid_o
);

  // a sample request occupies the block
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_SAMPLE)) |=> busy)
    else $error("sample request did not raise busy");

  // a load request gives no result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (kind_i == KIND_LOAD)) |=> (!busy && !result_valid_o))
    else $error("load request produced a result or busy");

  // busy drops only with a result
  a_fall_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  // results are single-cycle strobes
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held over two cycles");

  a_idle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

endmodule

bind piecewise_linear_bin_mapper plm_checker u_plm_checker (.*);

`default_nettype wire

// File: test/bin_map_checker.sv
// ----------------------------------------------------------------------------
// bin_map_checker
// Watches the request, result and register ports of the piecewise linear bin
// mapper, predicts every mapped result from its own copy of the breakpoint
// table and registers, and compares results in order against the predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bin_map_checker
  import plm_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic                          busy_i,
  input  wire logic                          kind_i,
  input  wire logic        [IDX_W-1:0]       entry_index_i,
  input  wire logic signed [VALUE_WIDTH-1:0] source_point_i,
  input  wire logic signed [VALUE_WIDTH-1:0] target_point_i,
  input  wire logic signed [VALUE_WIDTH-1:0] sample_value_i,
  input  wire logic                          cfg_we_i,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic        [VALUE_WIDTH-1:0] cfg_wdata_i,
  input  wire logic                          result_valid_i,
  input  wire logic signed [VALUE_WIDTH-1:0] mapped_value_i,
  input  wire logic                          saturated_i,
  output int                                 error_count_o,
  output int                                 pending_o
);

  localparam longint VMAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam int     MAX_REPORTS = 10;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   sat;
  } map_result_t;

  map_result_t expected_maps[$];

  logic signed [VALUE_WIDTH-1:0] src_tab [TABLE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] tgt_tab [TABLE_DEPTH];
  logic        [CNT_W-1:0]       bp_count;
  logic                          interp_en;
  logic                          clamp_below;
  logic                          clamp_above;
  logic signed [VALUE_WIDTH-1:0] below_val;
  logic signed [VALUE_WIDTH-1:0] above_val;
  int                            errors;

  function automatic void interp_bin(input longint v, input int lo, input int hi,
                                     output longint res, output logic sat);
    longint          s0, s1, t0, t1, ds, dt, num;
    longint unsigned mag;
    logic [127:0]    quo;
    s0  = src_tab[lo];
    s1  = src_tab[hi];
    t0  = tgt_tab[lo];
    t1  = tgt_tab[hi];
    ds  = s1 - s0;
    dt  = t1 - t0;
    num = v - s0;
    sat = 1'b0;
    res = t0;
    if (ds > 0 && num >= 0) begin
      mag = (dt < 0) ? -dt : dt;
      quo = ({64'd0, num} * {64'd0, mag}) / {64'd0, ds};
      res = (dt < 0) ? t0 - longint'(quo[63:0]) : t0 + longint'(quo[63:0]);
      if (res > VMAX) begin
        res = VMAX;
        sat = 1'b1;
      end
      if (res < VMIN) begin
        res = VMIN;
        sat = 1'b1;
      end
    end
  endfunction

  function automatic void map_sample(input logic signed [VALUE_WIDTH-1:0] sample_v,
                                     output map_result_t r);
    longint v, res;
    int     cnt, last, lo_b, hi_b, mid;
    logic   sat, found;
    cnt   = bp_count;
    if (cnt < 2) cnt = 2;
    if (cnt > TABLE_DEPTH) cnt = TABLE_DEPTH;
    last  = cnt - 1;
    v     = sample_v;
    res   = 0;
    sat   = 1'b0;
    found = 1'b0;
    if (v < src_tab[0]) begin
      res   = clamp_below ? tgt_tab[0] : below_val;
      found = 1'b1;
    end
    lo_b = 1;
    hi_b = last;
    while (!found && lo_b <= hi_b) begin
      mid = lo_b + (hi_b - lo_b) / 2;
      if (v >= src_tab[mid-1] && v < src_tab[mid]) begin
        if (interp_en) interp_bin(v, mid - 1, mid, res, sat);
        else res = tgt_tab[mid-1];
        found = 1'b1;
      end else if (v >= src_tab[mid]) begin
        lo_b = mid + 1;
      end else begin
        hi_b = mid - 1;
      end
    end
    if (!found) begin
      if (v > src_tab[last]) res = clamp_above ? tgt_tab[last] : above_val;
      else res = tgt_tab[last];
    end
    r.value = res[VALUE_WIDTH-1:0];
    r.sat   = sat;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : check_edge
    map_result_t predicted, oldest;
    if (!rst_ni) begin
      bp_count    = 5'd2;
      interp_en   = 1'b0;
      clamp_below = 1'b0;
      clamp_above = 1'b0;
      below_val   = '0;
      above_val   = '0;
      errors      = 0;
      expected_maps.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_COUNT:       bp_count    = cfg_wdata_i[CNT_W-1:0];
          CFG_INTERPOLATE: interp_en   = cfg_wdata_i[0];
          CFG_CLAMP_BELOW: clamp_below = cfg_wdata_i[0];
          CFG_CLAMP_ABOVE: clamp_above = cfg_wdata_i[0];
          CFG_BELOW_VALUE: below_val   = cfg_wdata_i;
          CFG_ABOVE_VALUE: above_val   = cfg_wdata_i;
          default: ;
        endcase
      end
      if (result_valid_i) begin
        if (expected_maps.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result value %h sat %b",
                     $realtime, mapped_value_i, saturated_i);
        end else begin
          oldest = expected_maps.pop_front();
          if (mapped_value_i !== oldest.value || saturated_i !== oldest.sat) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: mismatch expected value %h sat %b, got value %h sat %b",
                       $realtime, oldest.value, oldest.sat, mapped_value_i, saturated_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (kind_i == KIND_LOAD) begin
          src_tab[entry_index_i] = source_point_i;
          tgt_tab[entry_index_i] = target_point_i;
        end else begin
          map_sample(sample_value_i, predicted);
          expected_maps.push_back(predicted);
        end
      end
    end
    error_count_o <= errors;
    pending_o     <= expected_maps.size();
  end

endmodule

// File: test/tb_piecewise_linear_bin_mapper.sv
// ----------------------------------------------------------------------------
// tb_piecewise_linear_bin_mapper
// Drives table loads, register settings and sample requests into the bin
// mapper in random bursts, mostly over ascending tables with samples aimed at
// bins, breakpoints and both range ends, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_piecewise_linear_bin_mapper;
  import plm_pkg::*;

  localparam int     CLK_HALF       = 6;
  localparam int     RESET_CYCLES   = 11;
  localparam int     N_ITEMS        = 1450;
  localparam int     SETTLE_CYCLES  = 48;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam longint VMAX           = 64'sd2147483647;
  localparam longint VMIN           = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          start          = 1'b0;
  logic                          kind_i         = KIND_LOAD;
  logic        [IDX_W-1:0]       entry_index_i  = '0;
  logic signed [VALUE_WIDTH-1:0] source_point_i = '0;
  logic signed [VALUE_WIDTH-1:0] target_point_i = '0;
  logic signed [VALUE_WIDTH-1:0] sample_value_i = '0;
  logic                          cfg_we_i       = 1'b0;
  logic        [CFG_IDX_W-1:0]   cfg_addr_i     = CFG_COUNT;
  logic        [VALUE_WIDTH-1:0] cfg_wdata_i    = '0;
  wire logic                     busy;
  wire logic                     result_valid_o;
  wire logic signed [VALUE_WIDTH-1:0] mapped_value_o;
  wire logic                     saturated_o;
  int                            map_errors;
  int                            maps_pending;

  longint src_shadow [TABLE_DEPTH];
  longint tgt_shadow [TABLE_DEPTH];
  int     eff_count   = 2;
  int     items_sent  = 0;
  int     burst_left  = 0;
  int     stall_count = 0;

  piecewise_linear_bin_mapper u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .source_point_i (source_point_i),
    .target_point_i (target_point_i),
    .sample_value_i (sample_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .mapped_value_o (mapped_value_o),
    .saturated_o    (saturated_o)
  );

  bin_map_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .kind_i         (kind_i),
    .entry_index_i  (entry_index_i),
    .source_point_i (source_point_i),
    .target_point_i (target_point_i),
    .sample_value_i (sample_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_i (result_valid_o),
    .mapped_value_i (mapped_value_o),
    .saturated_i    (saturated_o),
    .error_count_o  (map_errors),
    .pending_o      (maps_pending)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // cycles with no request, result or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  function automatic longint rand_word();
    int w;
    w = $urandom;
    return w;
  endfunction

  function automatic longint rand_between(input longint a, input longint b);
    longint unsigned span, r;
    span = b - a + 1;
    r    = {$urandom, $urandom};
    return a + longint'(r % span);
  endfunction

  task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx,
                              input longint src, input longint tgt, input longint smp);
    int gap;
    @(negedge clk_i);
    start          <= 1'b1;
    kind_i         <= kind;
    entry_index_i  <= idx;
    source_point_i <= src[VALUE_WIDTH-1:0];
    target_point_i <= tgt[VALUE_WIDTH-1:0];
    sample_value_i <= smp[VALUE_WIDTH-1:0];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic load_pair(input int idx, input longint src, input longint tgt);
    src_shadow[idx] = src;
    tgt_shadow[idx] = tgt;
    send_request(KIND_LOAD, idx[IDX_W-1:0], src, tgt, rand_word());
  endtask

  task automatic map_request(input longint v);
    send_request(KIND_SAMPLE, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)),
                 rand_word(), rand_word(), v);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    @(posedge clk_i);
    while (maps_pending != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input longint data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data[VALUE_WIDTH-1:0];
    @(posedge clk_i);
  endtask

  task automatic configure(input int cnt, input logic interp, input logic cb,
                           input logic ca, input longint below, input longint above);
    wait_idle();
    write_reg(CFG_COUNT, cnt);
    write_reg(CFG_INTERPOLATE, interp);
    write_reg(CFG_CLAMP_BELOW, cb);
    write_reg(CFG_CLAMP_ABOVE, ca);
    write_reg(CFG_BELOW_VALUE, below);
    write_reg(CFG_ABOVE_VALUE, above);
    if ($urandom_range(0, 4) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, rand_word());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    eff_count = (cnt < 2) ? 2 : (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
  endtask

  initial begin
    int     count_corners [6];
    longint new_src [TABLE_DEPTH];
    longint total, v, a, b;
    int     cnt, mode, e, n, r, bin, last, idx;
    logic   rev, wild_tgt;
    count_corners = '{0, 1, 2, TABLE_DEPTH, TABLE_DEPTH + 1, 31};

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // full-span table, every entry written before the first sample
    for (int i = 0; i < TABLE_DEPTH; i++)
      load_pair(i, VMIN + i * 64'sd286331153, (i % 2 == 0) ? VMIN + 3 * i : VMAX - 5 * i);
    map_request(VMIN);
    map_request(VMAX);

    configure(TABLE_DEPTH, 1'b1, 1'b1, 1'b1, VMIN, VMAX);
    map_request(VMIN);
    map_request(VMAX);
    map_request(src_shadow[7]);
    map_request(src_shadow[7] - 1);

    // count above depth, first breakpoint raised so values fall below range
    configure(TABLE_DEPTH + 1, 1'b0, 1'b0, 1'b0, VMIN, VMAX);
    load_pair(0, -65536, VMIN);
    map_request(VMIN);
    map_request(src_shadow[3] + 5);

    while (items_sent < N_ITEMS) begin
      cnt = ($urandom_range(0, 3) == 0) ? count_corners[$urandom_range(0, 5)]
                                        : $urandom_range(2, TABLE_DEPTH);
      configure(cnt, $urandom_range(0, 4) < 3, $urandom_range(0, 1), $urandom_range(0, 1),
                ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? VMIN : VMAX)
                                            : rand_word(),
                ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? VMIN : VMAX)
                                            : rand_word());
      last = eff_count - 1;

      // new table: mostly ascending, sometimes crowded, rarely unordered
      mode  = $urandom_range(0, 9);
      e     = (mode == 1) ? 1 : $urandom_range(0, 27);
      total = 0;
      for (int i = 0; i < eff_count; i++) begin
        if (i > 0) total += $urandom_range((mode == 1) ? 0 : 1, 1 << e);
        new_src[i] = (mode == 0) ? rand_word() : total;
      end
      if (mode != 0) begin
        v = rand_between(VMIN, VMAX - total);
        for (int i = 0; i < eff_count; i++) new_src[i] += v;
      end
      rev      = $urandom_range(0, 1);
      wild_tgt = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < eff_count; i++) begin
        idx = rev ? eff_count - 1 - i : i;
        load_pair(idx, new_src[idx],
                  wild_tgt ? ((idx % 2 == 0) ? VMIN + idx : VMAX - idx) : rand_word());
      end

      n = $urandom_range(8, 40);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          load_pair($urandom_range(0, TABLE_DEPTH - 1), rand_word(), rand_word());
        end else begin
          if (r < 45) begin
            bin = $urandom_range(1, last);
            a   = src_shadow[bin-1];
            b   = src_shadow[bin];
            v   = (b > a) ? rand_between(a, b - 1) : a;
          end else if (r < 60) begin
            v = src_shadow[$urandom_range(0, last)];
          end else if (r < 70) begin
            v = (src_shadow[0] > VMIN) ? rand_between(VMIN, src_shadow[0] - 1) : VMIN;
          end else if (r < 80) begin
            v = (src_shadow[last] < VMAX) ? rand_between(src_shadow[last] + 1, VMAX)
                                          : VMAX;
          end else if (r < 85) begin
            case ($urandom_range(0, 3))
              0:       v = VMIN;
              1:       v = VMAX;
              2:       v = 0;
              default: v = -1;
            endcase
          end else begin
            v = rand_word();
          end
          map_request(v);
        end
      end
    end

    wait_idle();
    if (map_errors == 0 && maps_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
